[design/swmv_pkg.sv]
// ----------------------------------------------------------------------------
// swmv_pkg: shared types and constants for the sliding window statistics core
// Holds the controller state type and the fixed field widths of the item.
// ----------------------------------------------------------------------------
package swmv_pkg;

  // Fixed field widths of one input item and one result item.
  localparam int DATA_W = 16;
  localparam int VAR_W  = 31;
  localparam int STD_W  = 16;
  localparam int FILL_W = 4;

  // Largest value the variance field can hold.
  localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

  // Square root unit sizing: two radicand bits are consumed per step.
  localparam int SQRT_IN_W  = 2 * STD_W;
  localparam int SQRT_REM_W = STD_W + 3;
  localparam int SQRT_CNT_W = $clog2(STD_W + 1);

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_ACCUM,
    ST_MUL,
    ST_SUBTR,
    ST_DIV,
    ST_SQRT,
    ST_FINISH
  } swmv_state_t;

endpackage

[design/swmv_ram.sv]
// ----------------------------------------------------------------------------
// swmv_ram: generic single-clock RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module swmv_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 10,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/swmv_divider.sv]
// ----------------------------------------------------------------------------
// swmv_divider: serial restoring unsigned divider
// Produces one quotient bit per cycle while busy.
// ----------------------------------------------------------------------------
module swmv_divider #(
  parameter int DIVIDEND_W = 44,
  parameter int DIVISOR_W  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  // Partial remainder with the next dividend bit shifted in.
  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign fits  = (trial >= {1'b0, dvs});
  assign busy  = (cnt != '0);

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(DIVIDEND_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // Quotient and remainder datapath; the dividend shifts out as quotient bits enter.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DIVISOR_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DIVISOR_W-1:0];
      end
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

[design/swmv_isqrt.sv]
// ----------------------------------------------------------------------------
// swmv_isqrt: serial floor square root
// Digit-by-digit method, one root bit per cycle.
// ----------------------------------------------------------------------------
module swmv_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [swmv_pkg::VAR_W-1:0] radicand,
  output logic                      busy,
  output logic [swmv_pkg::STD_W-1:0] root
);

  import swmv_pkg::*;

  logic [SQRT_IN_W-1:0]  rad;
  logic [SQRT_REM_W-1:0] rem;
  logic [SQRT_CNT_W-1:0] cnt;
  logic [SQRT_REM_W-1:0] rem_shift;
  logic [SQRT_REM_W-1:0] trial;
  logic                  fits;

  // Bring down the next two radicand bits and try the next root bit.
  assign rem_shift = {rem[SQRT_REM_W-3:0], rad[SQRT_IN_W-1:SQRT_IN_W-2]};
  assign trial     = SQRT_REM_W'({root, 2'b01});
  assign fits      = (rem_shift >= trial);
  assign busy      = (cnt != '0);

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= SQRT_CNT_W'(STD_W);
    end else if (busy) begin
      cnt <= cnt - SQRT_CNT_W'(1);
    end
  end

  // Root and remainder datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= SQRT_IN_W'(radicand);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[SQRT_IN_W-3:0], 2'b00};
      if (fits) begin
        rem <= rem_shift - trial;
      end else begin
        rem <= rem_shift;
      end
      root <= {root[STD_W-2:0], fits};
    end
  end

endmodule

[design/sliding_window_mean_variance_core.sv]
// ----------------------------------------------------------------------------
// sliding_window_mean_variance_core: windowed mean, variance and std deviation
// Per item, from input accept to result valid: update and accumulate,
// clog2(WINDOW+1) shift-add steps for n*sum_sq, a subtract state, the serial
// variance divider (30+2*clog2(WINDOW+1) steps), the 16-step square root and
// a finish state. One item at a time: the next item is accepted once the core
// is back in idle, which a full output that stays stalled delays.
// Reset clears the window fill, pointer, sums and the output valid.
// ----------------------------------------------------------------------------
module sliding_window_mean_variance_core #(
  parameter int WINDOW = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic signed [swmv_pkg::DATA_W-1:0] sample,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [swmv_pkg::DATA_W-1:0] mean,
  output logic [swmv_pkg::VAR_W-1:0]        variance,
  output logic [swmv_pkg::STD_W-1:0]        std_dev,
  output logic [swmv_pkg::FILL_W-1:0]       fill_count
);

  import swmv_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = DATA_W + CNT_W;
  localparam int MAG_W  = SUM_W - 1;
  localparam int SQ_W   = 2 * DATA_W - 2 + CNT_W;
  localparam int NUM_W  = SQ_W + CNT_W;
  localparam int DEN_W  = 2 * CNT_W;
  localparam int MULC_W = $clog2(CNT_W + 1);

  swmv_state_t state, state_next;

  // Window bookkeeping and running sums.
  logic [PTR_W-1:0]         ptr;
  logic [CNT_W-1:0]         count;
  logic signed [SUM_W-1:0]  sum;
  logic [SQ_W-1:0]          sumsq;
  logic signed [DATA_W-1:0] sample_r;
  logic [2*DATA_W-2:0]      old_sq;
  logic [2*DATA_W-2:0]      new_sq;

  // Statistics datapath.
  logic                     neg;
  logic [NUM_W-1:0]         sum2;
  logic [DEN_W-1:0]         n_sq;
  logic [NUM_W-1:0]         acc;
  logic [CNT_W-1:0]         mul_b;
  logic [MULC_W-1:0]        mul_left;
  logic [VAR_W-1:0]         var_res;
  logic signed [DATA_W-1:0] mean_res;

  // Combinational helpers.
  logic                     full;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] old_val;
  logic signed [2*DATA_W-1:0] old_sq_full;
  logic signed [2*DATA_W-1:0] new_sq_full;
  logic signed [SUM_W-1:0]  sum_neg;
  logic [MAG_W-1:0]         mag;
  logic [NUM_W-1:0]         num;
  logic [VAR_W-1:0]         var_sat;
  logic [SUM_W-1:0]         mean_ext;
  logic [SUM_W-1:0]         mean_signed;

  // Control outputs of the sequencer.
  logic ram_rd_en;
  logic ram_wr_en;
  logic mean_start;
  logic var_start;
  logic sqrt_start;
  logic load_result;

  // Unit status.
  logic               mean_busy;
  logic               var_busy;
  logic               sqrt_busy;
  logic [MAG_W-1:0]   mean_q;
  logic [NUM_W-1:0]   var_q;
  logic [STD_W-1:0]   sqrt_root;

  // Window store.
  swmv_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WINDOW),
    .ADDR_W(PTR_W)
  ) u_window (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ptr),
    .wr_data(sample_r),
    .rd_en  (ram_rd_en),
    .rd_addr(ptr),
    .rd_data(ram_rdata)
  );

  // Mean divider: |sum| / count.
  swmv_divider #(
    .DIVIDEND_W(MAG_W),
    .DIVISOR_W (CNT_W)
  ) u_mean_div (
    .clk     (clk),
    .rst     (rst),
    .start   (mean_start),
    .dividend(mag),
    .divisor (count),
    .busy    (mean_busy),
    .quotient(mean_q)
  );

  // Variance divider: (n*sum_sq - sum^2) / n^2.
  swmv_divider #(
    .DIVIDEND_W(NUM_W),
    .DIVISOR_W (DEN_W)
  ) u_var_div (
    .clk     (clk),
    .rst     (rst),
    .start   (var_start),
    .dividend(num),
    .divisor (n_sq),
    .busy    (var_busy),
    .quotient(var_q)
  );

  // Square root of the saturated variance.
  swmv_isqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sqrt_start),
    .radicand(var_sat),
    .busy    (sqrt_busy),
    .root    (sqrt_root)
  );

  // Datapath helpers. The oldest sample only counts once the window is full.
  always_comb begin
    full        = (count == CNT_W'(WINDOW));
    old_val     = full ? signed'(ram_rdata) : '0;
    old_sq_full = old_val * old_val;
    new_sq_full = sample_r * sample_r;
    sum_neg     = -sum;
    mag         = sum[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum[MAG_W-1:0];
    num         = (acc >= sum2) ? (acc - sum2) : '0;
    var_sat     = (var_q > NUM_W'(VAR_MAX)) ? VAR_MAX : var_q[VAR_W-1:0];
    mean_ext    = {1'b0, mean_q};
    mean_signed = neg ? (~mean_ext + SUM_W'(1)) : mean_ext;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_ACCUM;
      ST_ACCUM:  state_next = ST_MUL;
      ST_MUL: begin
        if (mul_left == MULC_W'(1)) begin
          state_next = ST_SUBTR;
        end
      end
      ST_SUBTR:  state_next = ST_DIV;
      ST_DIV: begin
        if (!mean_busy && !var_busy) begin
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (!sqrt_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!result_valid || !result_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    sample_stall = (state != ST_IDLE);
    ram_rd_en    = (state == ST_IDLE) && sample_valid;
    ram_wr_en    = (state == ST_UPDATE);
    mean_start   = (state == ST_ACCUM);
    var_start    = (state == ST_SUBTR);
    sqrt_start   = (state == ST_DIV) && !mean_busy && !var_busy;
    load_result  = (state == ST_FINISH) && (!result_valid || !result_stall);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window pointer, fill count and running sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      count <= '0;
      sum   <= '0;
      sumsq <= '0;
    end else begin
      if (state == ST_UPDATE) begin
        sum <= sum - SUM_W'(old_val) + SUM_W'(sample_r);
        if (!full) begin
          count <= count + CNT_W'(1);
        end
        if (ptr == PTR_W'(WINDOW - 1)) begin
          ptr <= '0;
        end else begin
          ptr <= ptr + PTR_W'(1);
        end
      end
      if (state == ST_ACCUM) begin
        sumsq <= sumsq - SQ_W'(old_sq) + SQ_W'(new_sq);
      end
    end
  end

  // Item capture, squares, and the n*sum_sq shift-add multiplier.
  always_ff @(posedge clk) begin
    if (ram_rd_en) begin
      sample_r <= sample;
    end
    if (state == ST_UPDATE) begin
      old_sq <= old_sq_full[2*DATA_W-2:0];
      new_sq <= new_sq_full[2*DATA_W-2:0];
    end
    if (state == ST_ACCUM) begin
      neg      <= sum[SUM_W-1];
      sum2     <= NUM_W'(mag * mag);
      n_sq     <= DEN_W'(count * count);
      acc      <= '0;
      mul_b    <= count;
      mul_left <= MULC_W'(CNT_W);
    end
    if (state == ST_MUL) begin
      acc      <= {acc[NUM_W-2:0], 1'b0} + (mul_b[CNT_W-1] ? NUM_W'(sumsq) : '0);
      mul_b    <= mul_b << 1;
      mul_left <= mul_left - MULC_W'(1);
    end
    if (sqrt_start) begin
      var_res  <= var_sat;
      mean_res <= mean_signed[DATA_W-1:0];
    end
  end

  // Result register; the next item may start while a result waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      mean       <= mean_res;
      variance   <= var_res;
      std_dev    <= sqrt_root;
      fill_count <= FILL_W'(count);
    end
  end

  // Checks on the sequencer and window bookkeeping.
  a_accept_starts_update: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> (state == ST_UPDATE))
    else $error("accepted item did not move to update");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    ptr <= PTR_W'(WINDOW - 1))
    else $error("write pointer beyond window");

  a_div_done_before_sqrt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT) |-> (!mean_busy && !var_busy))
    else $error("square root started before division finished");

endmodule

[verif/sliding_window_mean_variance_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_mean_variance_checker: result checker for the window core
// Watches both channels of the core. Every accepted sample updates a private
// copy of the window, and the mean, variance, std deviation and fill count
// it implies are queued. Every accepted result is compared field by field
// against the oldest queued entry.
// ----------------------------------------------------------------------------
module sliding_window_mean_variance_checker #(
  parameter int WINDOW = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  input  logic                               sample_stall,
  input  logic signed [swmv_pkg::DATA_W-1:0] sample,
  input  logic                               result_valid,
  input  logic                               result_stall,
  input  logic signed [swmv_pkg::DATA_W-1:0] mean,
  input  logic [swmv_pkg::VAR_W-1:0]         variance,
  input  logic [swmv_pkg::STD_W-1:0]         std_dev,
  input  logic [swmv_pkg::FILL_W-1:0]        fill_count,
  output int                                 mismatch_count,
  output int                                 stats_in_flight
);
  import swmv_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] mean;
    logic [VAR_W-1:0]         variance;
    logic [STD_W-1:0]         std_dev;
    logic [FILL_W-1:0]        fill_count;
  } window_stats_t;

  // Private copy of the window and its running sums.
  logic signed [DATA_W-1:0] win_q [WINDOW];
  int unsigned              wr_ptr;
  int unsigned              held;
  longint                   run_sum;
  longint unsigned          run_sq;

  window_stats_t expected_stats_q [$];
  int            errs;

  initial begin
    mismatch_count  = 0;
    stats_in_flight = 0;
    errs            = 0;
  end

  // Largest r with r*r <= v, found one bit at a time from the top.
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  // Insert one sample into the window and work out the statistics it yields.
  function automatic window_stats_t next_window_stats(input logic signed [DATA_W-1:0] s);
    longint          cur;
    longint          oldest;
    longint          quot;
    longint          mag;
    longint unsigned nu;
    longint unsigned spread;
    longint unsigned mag_sq;
    longint unsigned var_full;
    longint unsigned root;
    window_stats_t   r;
    cur = s;
    // A full window drops its oldest sample from both sums first.
    if (held >= WINDOW) begin
      oldest = win_q[wr_ptr];
      run_sum = run_sum - oldest;
      run_sq  = run_sq - $unsigned(oldest * oldest);
    end else begin
      held++;
    end
    win_q[wr_ptr] = s;
    run_sum = run_sum + cur;
    run_sq  = run_sq + $unsigned(cur * cur);
    wr_ptr  = (wr_ptr + 1 >= WINDOW) ? 0 : wr_ptr + 1;

    nu   = held;
    quot = run_sum / longint'(held);
    // Exact population variance: (n*sum_sq - sum^2) / n^2.
    mag    = (run_sum < 0) ? -run_sum : run_sum;
    mag_sq = $unsigned(mag) * $unsigned(mag);
    spread = nu * run_sq;
    spread = (spread >= mag_sq) ? spread - mag_sq : 64'd0;
    var_full = spread / (nu * nu);
    if (var_full > VAR_MAX) var_full = VAR_MAX;
    root = floor_root(var_full);

    r.mean       = quot[DATA_W-1:0];
    r.variance   = var_full[VAR_W-1:0];
    r.std_dev    = root[STD_W-1:0];
    r.fill_count = nu[FILL_W-1:0];
    return r;
  endfunction

  // Both channels are sampled at the clock edge, results before samples.
  always @(posedge clk) begin : watch_channels
    window_stats_t want;
    if (rst) begin
      wr_ptr  = 0;
      held    = 0;
      run_sum = 0;
      run_sq  = 0;
      expected_stats_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_stats_q.size() == 0) begin
          errs++;
          $display("%0t: result with no sample pending, mean %0d variance %0d",
                   $time, mean, variance);
        end else begin
          want = expected_stats_q.pop_front();
          if (mean !== want.mean) begin
            errs++;
            $display("%0t: mean mismatch, expected %0d, actual %0d",
                     $time, want.mean, mean);
          end
          if (variance !== want.variance) begin
            errs++;
            $display("%0t: variance mismatch, expected %0d, actual %0d",
                     $time, want.variance, variance);
          end
          if (std_dev !== want.std_dev) begin
            errs++;
            $display("%0t: std_dev mismatch, expected %0d, actual %0d",
                     $time, want.std_dev, std_dev);
          end
          if (fill_count !== want.fill_count) begin
            errs++;
            $display("%0t: fill_count mismatch, expected %0d, actual %0d",
                     $time, want.fill_count, fill_count);
          end
        end
      end
      if (sample_valid && !sample_stall) begin
        expected_stats_q.push_back(next_window_stats(sample));
      end
    end
    mismatch_count  <= errs;
    stats_in_flight <= expected_stats_q.size();
  end

endmodule

[verif/sliding_window_mean_variance_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_mean_variance_core_tb: top level of the window core bench
// Feeds directed extremes and then segments of random samples (uniform,
// clustered, extreme and constant) with random gaps and result stalls, one
// long result hold-off and several full drains. A separate checker predicts
// and compares; this module only drives the core and gives the verdict.
// ----------------------------------------------------------------------------
module sliding_window_mean_variance_core_tb;
  import swmv_pkg::*;

  localparam int WINDOW       = 10;
  localparam int RANDOM_ITEMS = 1800;
  localparam int LONG_HOLD    = 500;
  localparam int SETTLE       = 150;
  localparam int QUIET_LIMIT  = 4000;
  localparam int N_DIRECTED   = 25;

  // Extremes first, then alternating extremes past the wrap, then a flat window.
  localparam logic signed [DATA_W-1:0] DIRECTED [N_DIRECTED] = '{
    16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
    16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
    16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
    16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
    16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000
  };

  typedef enum int {SRC_UNIFORM, SRC_NEAR, SRC_EXTREME, SRC_CONST} sample_src_t;

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     sample_valid = 1'b0;
  logic                     sample_stall;
  logic signed [DATA_W-1:0] sample       = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic signed [DATA_W-1:0] mean;
  logic [VAR_W-1:0]         variance;
  logic [STD_W-1:0]         std_dev;
  logic [FILL_W-1:0]        fill_count;

  int mismatch_count;
  int stats_in_flight;
  int quiet_cycles  = 0;
  bit no_idle       = 1'b0;
  bit long_hold_req = 1'b0;

  always #2 clk = ~clk;

  sliding_window_mean_variance_core #(
    .WINDOW(WINDOW)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .mean         (mean),
    .variance     (variance),
    .std_dev      (std_dev),
    .fill_count   (fill_count)
  );

  sliding_window_mean_variance_checker #(
    .WINDOW(WINDOW)
  ) i_checker (
    .clk             (clk),
    .rst             (rst),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .sample          (sample),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .mean            (mean),
    .variance        (variance),
    .std_dev         (std_dev),
    .fill_count      (fill_count),
    .mismatch_count  (mismatch_count),
    .stats_in_flight (stats_in_flight)
  );

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(10, 0);
  endfunction

  // Offers one item after an optional gap and returns once it is taken.
  task automatic push_sample(input logic signed [DATA_W-1:0] v, input int gap);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= v;
    do @(posedge clk); while (sample_stall);
  endtask

  // Stops offering and waits until every queued result has come back.
  task automatic wait_for_drain();
    sample_valid <= 1'b0;
    do @(posedge clk); while (stats_in_flight != 0);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_sample(
    input sample_src_t src, input logic signed [DATA_W-1:0] base);
    logic signed [DATA_W-1:0] v;
    case (src)
      SRC_UNIFORM: v = DATA_W'($urandom);
      SRC_NEAR:    v = 16'(int'(base) + int'($urandom_range(400, 0)) - 200);
      SRC_EXTREME: begin
        case ($urandom_range(3, 0))
          0:       v = 16'sh7FFF;
          1:       v = 16'sh8000;
          2:       v = 16'sh0000;
          default: v = 16'shFFFF;
        endcase
      end
      default:     v = base;
    endcase
    return v;
  endfunction

  // Result side: random stalls per item, plus one long hold-off on request.
  initial begin : take_results
    int stall_cycles;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end
      stall_cycles = no_idle ? 0 : $urandom_range(10, 0);
      if (stall_cycles > 0) begin
        result_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
    end
  end

  // Sample side: reset, directed items, then random segments.
  initial begin : feed_samples
    int                       sent;
    int                       seg;
    int                       seg_len;
    sample_src_t              src;
    logic signed [DATA_W-1:0] base;
    sent = 0;
    seg  = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < N_DIRECTED; k++) begin
      push_sample(DIRECTED[k], draw_gap());
    end
    wait_for_drain();

    while (sent < RANDOM_ITEMS) begin
      src     = sample_src_t'($urandom_range(3, 0));
      base    = DATA_W'($urandom);
      seg_len = $urandom_range(60, 20);
      no_idle = ($urandom_range(3, 0) == 0);
      // One segment runs under a long result hold-off so the core backs up.
      if (seg == 3) long_hold_req = 1'b1;
      for (int k = 0; k < seg_len; k++) begin
        push_sample(pick_sample(src, base), draw_gap());
      end
      sent += seg_len;
      if (seg % 10 == 6) wait_for_drain();
      seg++;
    end

    no_idle = 1'b0;
    wait_for_drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && stats_in_flight == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
